/* src/ppcc_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the pairwise proximity collision check.
// Used by the sequencer and the top level; depends on nothing else.
package ppcc_pkg;

    // Fixed field widths of the request and result channels.
    localparam int unsigned FIELD_COORD_W = 20;
    localparam int unsigned FIELD_ROBOT_W = 3;
    localparam int unsigned LIMIT_W       = 16;
    localparam int unsigned LIM2_W        = 2 * LIMIT_W;

    // Reset value of the near limit register, in millimeters.
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd400;

    // Result kind codes.
    localparam logic KIND_PAIR    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // One position request.
    typedef struct packed {
        logic                            new_run;
        logic [FIELD_ROBOT_W-1:0]        robot;
        logic signed [FIELD_COORD_W-1:0] pos_x;
        logic signed [FIELD_COORD_W-1:0] pos_y;
        logic signed [FIELD_COORD_W-1:0] pos_z;
        logic                            step_done;
    } req_t;

    // One result: a close pair report or a timestep summary.
    typedef struct packed {
        logic                            kind;
        logic [FIELD_ROBOT_W-1:0]        robot_a;
        logic [FIELD_ROBOT_W-1:0]        robot_b;
        logic signed [FIELD_COORD_W-1:0] hit_x;
        logic signed [FIELD_COORD_W-1:0] hit_y;
        logic signed [FIELD_COORD_W-1:0] hit_z;
        logic                            step_hit;
        logic                            any_hit;
        logic                            last;
    } result_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LIM_ISSUE,
        ST_LIM_WAIT,
        ST_LIM_LATCH,
        ST_SEEK,
        ST_MUL_X,
        ST_MUL_Y,
        ST_MUL_Z,
        ST_ACC_Y,
        ST_ACC_Z,
        ST_SUMMARY
    } state_t;

endpackage

/* src/ppcc_point_mem.sv */
`timescale 1ns / 1ps
// Position store: one write port and two registered read ports.
// Holds the latest point of each robot; standalone, no package use.
module ppcc_point_mem #(
    parameter int unsigned DEPTH  = 8,
    parameter int unsigned WIDTH  = 60,
    parameter int unsigned ADDR_W = 3
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_a_addr,
    input  logic [ADDR_W-1:0] rd_b_addr,
    output logic [WIDTH-1:0]  rd_a_data,
    output logic [WIDTH-1:0]  rd_b_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_a_reg;
    logic [WIDTH-1:0] rd_b_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Two read ports with registered data.
    always_ff @(posedge clk)
    begin
        rd_a_reg <= mem[rd_a_addr];
        rd_b_reg <= mem[rd_b_addr];
    end

    assign rd_a_data = rd_a_reg;
    assign rd_b_data = rd_b_reg;

endmodule

/* src/ppcc_sq_unit.sv */
`timescale 1ns / 1ps
// Shared difference-square unit: (a - b)^2 over two register stages.
// Standalone, no package use.
module ppcc_sq_unit #(
    parameter int unsigned DW = 21
) (
    input  logic                 clk,
    input  logic signed [DW-1:0] op_a,
    input  logic signed [DW-1:0] op_b,
    output logic [2*DW-1:0]      prod
);

    logic signed [DW-1:0]   diff_reg;
    logic signed [2*DW-1:0] prod_reg;

    // Stage one: difference. Operands stay within DW-1 bits, so no overflow.
    always_ff @(posedge clk)
    begin
        diff_reg <= op_a - op_b;
    end

    // Stage two: square of the difference, never negative.
    always_ff @(posedge clk)
    begin
        prod_reg <= diff_reg * diff_reg;
    end

    assign prod = prod_reg;

endmodule

/* src/ppcc_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer: request intake, valid marks, pair walk, accumulate and compare,
// result register. Uses ppcc_pkg, drives ppcc_point_mem and ppcc_sq_unit.
module ppcc_ctrl #(
    parameter int unsigned ROBOTS     = 8,
    parameter int unsigned COORD_BITS = 20,
    parameter int unsigned IW         = 3,
    parameter int unsigned DW         = 21
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  ppcc_pkg::req_t                       req,
    input  logic [ppcc_pkg::LIMIT_W-1:0]         limit,
    output logic                                 busy,
    output logic                                 result_valid,
    output ppcc_pkg::result_t                    result,
    output logic                                 wr_en,
    output logic [IW-1:0]                        wr_addr,
    output logic [3*COORD_BITS-1:0]              wr_data,
    output logic [IW-1:0]                        rd_a_addr,
    output logic [IW-1:0]                        rd_b_addr,
    input  logic [3*COORD_BITS-1:0]              rd_a_data,
    input  logic [3*COORD_BITS-1:0]              rd_b_data,
    output logic signed [DW-1:0]                 op_a,
    output logic signed [DW-1:0]                 op_b,
    input  logic [2*DW-1:0]                      prod
);

    localparam int unsigned CW   = COORD_BITS;
    localparam int unsigned FW   = ppcc_pkg::FIELD_COORD_W;
    localparam int unsigned PADW = (CW > FW) ? CW : FW;
    localparam int unsigned SW   = 2 * DW + 2;
    localparam int unsigned RW   = ppcc_pkg::FIELD_ROBOT_W;

    ppcc_pkg::state_t                state_reg, state_next;
    logic [ROBOTS-1:0]               valid_reg, valid_next;
    logic                            run_hit_reg, run_hit_next;
    logic                            step_hit_reg, step_hit_next;
    logic [IW-1:0]                   i_reg, i_next;
    logic [IW-1:0]                   j_reg, j_next;
    logic [ppcc_pkg::LIM2_W-1:0]     lim2_reg, lim2_next;
    logic [SW-1:0]                   acc_reg, acc_next;
    logic                            result_valid_reg, result_valid_next;
    ppcc_pkg::result_t               result_reg, result_next;

    logic                            accept;
    logic                            robot_ok;
    logic [PADW-1:0]                 px_pad, py_pad, pz_pad;
    logic [CW-1:0]                   in_x, in_y, in_z;
    logic signed [DW-1:0]            ax, ay, az, bx, by, bz;
    logic [SW-1:0]                   d2;
    logic                            pair_close;
    logic                            last_pair;
    logic [IW-1:0]                   i_adv, j_adv;
    logic [PADW-1:0]                 hx_ext, hy_ext, hz_ext;

    assign accept   = start && (state_reg == ppcc_pkg::ST_IDLE);
    assign busy     = (state_reg != ppcc_pkg::ST_IDLE);
    assign robot_ok = ({1'b0, req.robot} < (RW+1)'(ROBOTS));

    // Request coordinates reduced to the stored width.
    assign px_pad = PADW'(unsigned'(req.pos_x));
    assign py_pad = PADW'(unsigned'(req.pos_y));
    assign pz_pad = PADW'(unsigned'(req.pos_z));
    assign in_x   = px_pad[CW-1:0];
    assign in_y   = py_pad[CW-1:0];
    assign in_z   = pz_pad[CW-1:0];

    // Memory write on an accepted request with an index in range.
    assign wr_en     = accept && robot_ok;
    assign wr_addr   = req.robot[IW-1:0];
    assign wr_data   = {in_z, in_y, in_x};
    assign rd_a_addr = i_reg;
    assign rd_b_addr = j_reg;

    // Stored points sign-extended to the unit width.
    assign ax = DW'($signed(rd_a_data[CW-1:0]));
    assign ay = DW'($signed(rd_a_data[2*CW-1:CW]));
    assign az = DW'($signed(rd_a_data[3*CW-1:2*CW]));
    assign bx = DW'($signed(rd_b_data[CW-1:0]));
    assign by = DW'($signed(rd_b_data[2*CW-1:CW]));
    assign bz = DW'($signed(rd_b_data[3*CW-1:2*CW]));

    // Robot a's point as reported on the 20-bit result fields.
    assign hx_ext = PADW'($signed(rd_a_data[CW-1:0]));
    assign hy_ext = PADW'($signed(rd_a_data[2*CW-1:CW]));
    assign hz_ext = PADW'($signed(rd_a_data[3*CW-1:2*CW]));

    // Final sum of the three squares and the threshold compare.
    assign d2         = acc_reg + SW'(prod);
    assign pair_close = (d2 < SW'(lim2_reg));

    // Next pair in index order.
    always_comb
    begin
        last_pair = 1'b0;
        i_adv     = i_reg;
        j_adv     = j_reg;
        if (j_reg == IW'(ROBOTS - 1))
        begin
            if (i_reg == IW'(ROBOTS - 2))
            begin
                last_pair = 1'b1;
            end
            else
            begin
                i_adv = IW'(i_reg + 2'd1);
                j_adv = IW'(i_reg + 2'd2);
            end
        end
        else
        begin
            j_adv = IW'(j_reg + 1'b1);
        end
    end

    // State and data registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ppcc_pkg::ST_IDLE;
            valid_reg        <= '0;
            run_hit_reg      <= 1'b0;
            step_hit_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            valid_reg        <= valid_next;
            run_hit_reg      <= run_hit_next;
            step_hit_reg     <= step_hit_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg      <= i_next;
        j_reg      <= j_next;
        lim2_reg   <= lim2_next;
        acc_reg    <= acc_next;
        result_reg <= result_next;
    end

    // Next state, unit operands and results.
    always_comb
    begin
        state_next        = state_reg;
        valid_next        = valid_reg;
        run_hit_next      = run_hit_reg;
        step_hit_next     = step_hit_reg;
        i_next            = i_reg;
        j_next            = j_reg;
        lim2_next         = lim2_reg;
        acc_next          = acc_reg;
        result_valid_next = 1'b0;
        result_next       = '0;
        op_a              = ax;
        op_b              = bx;

        unique case (state_reg)
            ppcc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.new_run)
                    begin
                        valid_next   = '0;
                        run_hit_next = 1'b0;
                    end
                    if (robot_ok)
                    begin
                        valid_next[req.robot[IW-1:0]] = 1'b1;
                    end
                    if (req.step_done)
                    begin
                        step_hit_next = 1'b0;
                        i_next        = '0;
                        j_next        = IW'(1);
                        state_next    = ppcc_pkg::ST_LIM_ISSUE;
                    end
                end
            end

            // Square the limit once per timestep on the shared unit.
            ppcc_pkg::ST_LIM_ISSUE:
            begin
                op_a       = DW'({1'b0, limit});
                op_b       = '0;
                state_next = ppcc_pkg::ST_LIM_WAIT;
            end

            ppcc_pkg::ST_LIM_WAIT:
            begin
                state_next = ppcc_pkg::ST_LIM_LATCH;
            end

            ppcc_pkg::ST_LIM_LATCH:
            begin
                lim2_next  = prod[ppcc_pkg::LIM2_W-1:0];
                state_next = ppcc_pkg::ST_SEEK;
            end

            // Skip pairs with an unwritten robot; read points for a live pair.
            ppcc_pkg::ST_SEEK:
            begin
                if (valid_reg[i_reg] && valid_reg[j_reg])
                begin
                    state_next = ppcc_pkg::ST_MUL_X;
                end
                else if (last_pair)
                begin
                    state_next = ppcc_pkg::ST_SUMMARY;
                end
                else
                begin
                    i_next = i_adv;
                    j_next = j_adv;
                end
            end

            ppcc_pkg::ST_MUL_X:
            begin
                op_a       = ax;
                op_b       = bx;
                state_next = ppcc_pkg::ST_MUL_Y;
            end

            ppcc_pkg::ST_MUL_Y:
            begin
                op_a       = ay;
                op_b       = by;
                state_next = ppcc_pkg::ST_MUL_Z;
            end

            // The x square arrives as the z difference is issued.
            ppcc_pkg::ST_MUL_Z:
            begin
                op_a       = az;
                op_b       = bz;
                acc_next   = SW'(prod);
                state_next = ppcc_pkg::ST_ACC_Y;
            end

            ppcc_pkg::ST_ACC_Y:
            begin
                acc_next   = acc_reg + SW'(prod);
                state_next = ppcc_pkg::ST_ACC_Z;
            end

            // Compare, report a close pair and move on.
            ppcc_pkg::ST_ACC_Z:
            begin
                if (pair_close)
                begin
                    step_hit_next       = 1'b1;
                    result_valid_next   = 1'b1;
                    result_next.kind    = ppcc_pkg::KIND_PAIR;
                    result_next.robot_a = RW'(i_reg);
                    result_next.robot_b = RW'(j_reg);
                    result_next.hit_x   = hx_ext[FW-1:0];
                    result_next.hit_y   = hy_ext[FW-1:0];
                    result_next.hit_z   = hz_ext[FW-1:0];
                end
                if (last_pair)
                begin
                    state_next = ppcc_pkg::ST_SUMMARY;
                end
                else
                begin
                    i_next     = i_adv;
                    j_next     = j_adv;
                    state_next = ppcc_pkg::ST_SEEK;
                end
            end

            // Close the timestep with the summary result.
            ppcc_pkg::ST_SUMMARY:
            begin
                run_hit_next         = run_hit_reg || step_hit_reg;
                result_valid_next    = 1'b1;
                result_next.kind     = ppcc_pkg::KIND_SUMMARY;
                result_next.step_hit = step_hit_reg;
                result_next.any_hit  = run_hit_reg || step_hit_reg;
                result_next.last     = 1'b1;
                state_next           = ppcc_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = ppcc_pkg::ST_IDLE;
            end
        endcase
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

/* src/pairwise_proximity_collision_check_core.sv */
`timescale 1ns / 1ps
// Top level of the pairwise proximity collision check: APB register port
// and the sequencer, position store and shared square unit. Uses ppcc_pkg.
//
// Usage:
//   A request (req) is taken at a rising edge with start high and busy low.
//   Each request stores one robot's position; new_run first forgets all
//   stored positions and the run-wide hit flag. A request without step_done
//   gives no result.
//   A request with step_done walks every robot pair in index order on one
//   shared difference-square unit: it squares the limit, then checks each
//   pair of stored robots in turn, and ends the timestep with the summary.
//   Each close pair gives a report (kind 0); a summary (kind 1, last high)
//   ends the timestep. Each result is shown for exactly one cycle with
//   result_valid high; the receiver takes it then and cannot stall.
//   busy is high from the cycle after a step request until the summary.
//   near_limit_mm sits at byte address 0 of the APB port. It must be written
//   only while busy is low; the block itself does not enforce this.
//   Reset clears the valid marks, the hit flag and the sequencer and
//   restores the limit to 400 mm; no clearing pass.
module pairwise_proximity_collision_check_core #(
    parameter int unsigned ROBOTS     = 8,
    parameter int unsigned COORD_BITS = 20
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  ppcc_pkg::req_t           req,
    output logic                     busy,
    output logic                     result_valid,
    output ppcc_pkg::result_t        result,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [1:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    localparam int unsigned IW = (ROBOTS > 1) ? $clog2(ROBOTS) : 1;
    localparam int unsigned DW = (COORD_BITS + 1 > ppcc_pkg::LIMIT_W + 1)
                               ? COORD_BITS + 1 : ppcc_pkg::LIMIT_W + 1;

    logic [ppcc_pkg::LIMIT_W-1:0] limit_reg, limit_next;
    logic                         cfg_write;

    logic                         wr_en;
    logic [IW-1:0]                wr_addr;
    logic [3*COORD_BITS-1:0]      wr_data;
    logic [IW-1:0]                rd_a_addr, rd_b_addr;
    logic [3*COORD_BITS-1:0]      rd_a_data, rd_b_data;
    logic signed [DW-1:0]         op_a, op_b;
    logic [2*DW-1:0]              prod;

    // Register port: one register, so every word address maps to it.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = {{(32 - ppcc_pkg::LIMIT_W){1'b0}}, limit_reg}
                     | {30'b0, paddr & 2'b00};

    always_comb
    begin
        limit_next = limit_reg;
        if (cfg_write)
        begin
            limit_next = pwdata[ppcc_pkg::LIMIT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= ppcc_pkg::LIMIT_RESET;
        end
        else
        begin
            limit_reg <= limit_next;
        end
    end

    // Sequencer.
    ppcc_ctrl #(
        .ROBOTS     (ROBOTS),
        .COORD_BITS (COORD_BITS),
        .IW         (IW),
        .DW         (DW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .req          (req),
        .limit        (limit_reg),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .rd_a_addr    (rd_a_addr),
        .rd_b_addr    (rd_b_addr),
        .rd_a_data    (rd_a_data),
        .rd_b_data    (rd_b_data),
        .op_a         (op_a),
        .op_b         (op_b),
        .prod         (prod)
    );

    // Position store.
    ppcc_point_mem #(
        .DEPTH  (ROBOTS),
        .WIDTH  (3 * COORD_BITS),
        .ADDR_W (IW)
    ) u_mem (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_a_addr (rd_a_addr),
        .rd_b_addr (rd_b_addr),
        .rd_a_data (rd_a_data),
        .rd_b_data (rd_b_data)
    );

    // Shared difference-square unit.
    ppcc_sq_unit #(
        .DW (DW)
    ) u_sq (
        .clk  (clk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

endmodule

/* test/tb_pairwise_proximity_collision_check_core.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the pairwise proximity collision check core.
// Depends on ppcc_pkg and pairwise_proximity_collision_check_core only.
module tb_pairwise_proximity_collision_check_core;

    localparam int unsigned ROBOT_COUNT   = 8;
    localparam int unsigned COORD_W       = 20;
    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          DRAIN_CYCLES  = 8;
    localparam logic [1:0]  ADDR_NEAR_LIMIT = 2'd0;
    localparam int          COORD_MAX     = 524287;
    localparam int          COORD_MIN     = -524288;

    // Directed rows either issue a request or rewrite the near limit.
    typedef enum logic { ROW_REQ, ROW_CFG } row_kind_t;

    typedef struct {
        row_kind_t            kind;
        ppcc_pkg::req_t       r;
        int                   n_typed;
        ppcc_pkg::result_t    exp_a;
        ppcc_pkg::result_t    exp_b;
        logic [15:0]          limit;
    } row_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    ppcc_pkg::req_t    req;
    logic              busy;
    logic              result_valid;
    ppcc_pkg::result_t result;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [1:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    // Shadow copy of the fleet as the block should hold it.
    logic signed [COORD_W-1:0]        fleet_x [ROBOT_COUNT];
    logic signed [COORD_W-1:0]        fleet_y [ROBOT_COUNT];
    logic signed [COORD_W-1:0]        fleet_z [ROBOT_COUNT];
    logic [ROBOT_COUNT-1:0]           fleet_valid;
    logic                             fleet_hit;
    logic [ppcc_pkg::LIMIT_W-1:0]     near_limit;

    ppcc_pkg::result_t owed_reports [$];
    row_t              directed [$];

    int sender_gap_pct;
    int mismatches;
    int requests_sent;
    int pair_reports;
    int summaries;
    int limit_settings;
    int cycle_count;

    pairwise_proximity_collision_check_core #(
        .ROBOTS     (ROBOT_COUNT),
        .COORD_BITS (COORD_W)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .req          (req),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic ppcc_pkg::req_t mk_req(input bit nr, input int robot, input int x,
                                              input int y, input int z, input bit sd);
        ppcc_pkg::req_t r;
        r.new_run   = nr;
        r.robot     = 3'(robot);
        r.pos_x     = 20'(x);
        r.pos_y     = 20'(y);
        r.pos_z     = 20'(z);
        r.step_done = sd;
        return r;
    endfunction

    function automatic ppcc_pkg::result_t mk_pair(input int a, input int b, input int x,
                                                  input int y, input int z);
        ppcc_pkg::result_t o;
        o         = '0;
        o.kind    = ppcc_pkg::KIND_PAIR;
        o.robot_a = 3'(a);
        o.robot_b = 3'(b);
        o.hit_x   = 20'(x);
        o.hit_y   = 20'(y);
        o.hit_z   = 20'(z);
        return o;
    endfunction

    function automatic ppcc_pkg::result_t mk_summary(input bit step_hit, input bit any_hit);
        ppcc_pkg::result_t o;
        o          = '0;
        o.kind     = ppcc_pkg::KIND_SUMMARY;
        o.step_hit = step_hit;
        o.any_hit  = any_hit;
        o.last     = 1'b1;
        return o;
    endfunction

    function automatic row_t req_row(input ppcc_pkg::req_t r, input int n,
                                     input ppcc_pkg::result_t a,
                                     input ppcc_pkg::result_t b);
        row_t w;
        w.kind    = ROW_REQ;
        w.r       = r;
        w.n_typed = n;
        w.exp_a   = a;
        w.exp_b   = b;
        w.limit   = '0;
        return w;
    endfunction

    function automatic row_t cfg_row(input logic [15:0] limit);
        row_t w;
        w.kind    = ROW_CFG;
        w.r       = '0;
        w.n_typed = 0;
        w.exp_a   = '0;
        w.exp_b   = '0;
        w.limit   = limit;
        return w;
    endfunction

    // Append one expected result to the scoreboard queue.
    function automatic void owe_result(input ppcc_pkg::result_t o);
        owed_reports = {owed_reports, o};
    endfunction

    // Append one row to the directed table.
    function automatic void add_row(input row_t w);
        directed = {directed, w};
    endfunction

    // Limits for the random part: the extremes, tiny ones, typical ones and any 16-bit value.
    function automatic logic [15:0] pick_limit();
        case ($urandom_range(5))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(1, 16));
            5: return 16'($urandom_range(65535));
            default: return 16'($urandom_range(100, 3000));
        endcase
    endfunction

    // Apply one request to the shadow fleet and, on a step end, scan all pairs.
    // The reports it owes are queued when keep is set.
    task automatic scan_pairs(input ppcc_pkg::req_t r, input bit keep);
        longint dx;
        longint dy;
        longint dz;
        longint lim2;
        ppcc_pkg::result_t o;
        bit step_hit;
        step_hit = 1'b0;
        if (r.new_run)
        begin
            fleet_valid = '0;
            fleet_hit   = 1'b0;
        end
        fleet_x[r.robot]     = r.pos_x;
        fleet_y[r.robot]     = r.pos_y;
        fleet_z[r.robot]     = r.pos_z;
        fleet_valid[r.robot] = 1'b1;
        if (!r.step_done)
            return;
        lim2 = longint'(near_limit) * longint'(near_limit);
        for (int i = 0; i < ROBOT_COUNT; i++)
        begin
            for (int j = i + 1; j < ROBOT_COUNT; j++)
            begin
                if (fleet_valid[i] && fleet_valid[j])
                begin
                    dx = longint'(fleet_x[i]) - longint'(fleet_x[j]);
                    dy = longint'(fleet_y[i]) - longint'(fleet_y[j]);
                    dz = longint'(fleet_z[i]) - longint'(fleet_z[j]);
                    if (dx * dx + dy * dy + dz * dz < lim2)
                    begin
                        step_hit = 1'b1;
                        o = mk_pair(i, j, 0, 0, 0);
                        o.hit_x = fleet_x[i];
                        o.hit_y = fleet_y[i];
                        o.hit_z = fleet_z[i];
                        if (keep)
                            owe_result(o);
                    end
                end
            end
        end
        if (step_hit)
            fleet_hit = 1'b1;
        if (keep)
            owe_result(mk_summary(step_hit, fleet_hit));
    endtask

    // Present one request, idling at random first, and hold it until taken.
    task automatic send_request(input ppcc_pkg::req_t r, input bit keep);
        while ($urandom_range(99) < sender_gap_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        req   <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        scan_pairs(r, keep);
        requests_sent++;
    endtask

    // Let the block run dry: nothing owed and not busy, then a drain period.
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (owed_reports.size() != 0 || busy)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    // APB write of the near limit: setup cycle, then access until pready.
    task automatic write_near_limit(input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_NEAR_LIMIT;
        pwdata  <= {16'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        near_limit = value;
        limit_settings++;
        @(posedge clk);
    endtask

    // Random timesteps: clustered positions around the limit, with some
    // full-range points, early step ends and stray run restarts as noise.
    task automatic run_random_steps(input int n_items, input int gap_pct);
        int sent;
        int n_bots;
        int spread;
        int cx;
        int cy;
        int cz;
        int c [3];
        bit fresh;
        bit sd;
        bit nr;
        ppcc_pkg::req_t r;
        sent = 0;
        sender_gap_pct = gap_pct;
        while (sent < n_items)
        begin
            if ($urandom_range(5) == 0)
            begin
                wait_idle();
                write_near_limit(pick_limit());
            end
            spread = (near_limit == 0) ? 64 : int'(near_limit);
            cx = int'($urandom_range(900000)) - 450000;
            cy = int'($urandom_range(900000)) - 450000;
            cz = int'($urandom_range(900000)) - 450000;
            n_bots = $urandom_range(1, 8);
            fresh = ($urandom_range(7) == 0);
            for (int k = 0; k < n_bots; k++)
            begin
                if ($urandom_range(7) == 0)
                begin
                    c[0] = int'($urandom());
                    c[1] = int'($urandom());
                    c[2] = int'($urandom());
                end
                else
                begin
                    c[0] = cx + int'($urandom_range(spread)) - spread / 2;
                    c[1] = cy + int'($urandom_range(spread)) - spread / 2;
                    c[2] = cz + int'($urandom_range(spread)) - spread / 2;
                end
                nr = (fresh && k == 0) || ($urandom_range(39) == 0);
                sd = (k == n_bots - 1) || ($urandom_range(19) == 0);
                r = mk_req(nr, $urandom_range(7), c[0], c[1], c[2], sd);
                send_request(r, 1'b1);
                sent++;
            end
        end
    endtask

    // Compare one result, field by field, against the oldest owed report.
    task automatic check_result(input ppcc_pkg::result_t got);
        ppcc_pkg::result_t want;
        if (owed_reports.size() == 0)
        begin
            $error("unexpected result with nothing owed: kind %0d", got.kind);
            mismatches++;
            return;
        end
        want = owed_reports.pop_front();
        if (want.kind == ppcc_pkg::KIND_SUMMARY)
            summaries++;
        else
            pair_reports++;
        if (got.kind !== want.kind)
        begin
            $error("kind: expected %0d, got %0d", want.kind, got.kind);
            mismatches++;
        end
        if (got.robot_a !== want.robot_a)
        begin
            $error("robot_a: expected %0d, got %0d", want.robot_a, got.robot_a);
            mismatches++;
        end
        if (got.robot_b !== want.robot_b)
        begin
            $error("robot_b: expected %0d, got %0d", want.robot_b, got.robot_b);
            mismatches++;
        end
        if (got.hit_x !== want.hit_x)
        begin
            $error("hit_x: expected %0d, got %0d", want.hit_x, got.hit_x);
            mismatches++;
        end
        if (got.hit_y !== want.hit_y)
        begin
            $error("hit_y: expected %0d, got %0d", want.hit_y, got.hit_y);
            mismatches++;
        end
        if (got.hit_z !== want.hit_z)
        begin
            $error("hit_z: expected %0d, got %0d", want.hit_z, got.hit_z);
            mismatches++;
        end
        if (got.step_hit !== want.step_hit)
        begin
            $error("step_hit: expected %0d, got %0d", want.step_hit, got.step_hit);
            mismatches++;
        end
        if (got.any_hit !== want.any_hit)
        begin
            $error("any_hit: expected %0d, got %0d", want.any_hit, got.any_hit);
            mismatches++;
        end
        if (got.last !== want.last)
        begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            mismatches++;
        end
    endtask

    // Results are taken at the edge that ends their single valid cycle.
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            check_result(result);
    end

    // Watchdog on the whole run.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("run stopped by the watchdog after %0d cycles", cycle_count);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Main sequence: reset, directed table, three random phases, drain.
    initial
    begin
        rst_n   <= 1'b0;
        start   <= 1'b0;
        req     <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        fleet_valid    = '0;
        fleet_hit      = 1'b0;
        near_limit     = ppcc_pkg::LIMIT_RESET;
        mismatches     = 0;
        requests_sent  = 0;
        pair_reports   = 0;
        summaries      = 0;
        limit_settings = 0;
        sender_gap_pct = 38;

        // Reset limit, the exact threshold edge, coordinate extremes, run
        // restarts, a zero limit, the widest limit and a limit of one.
        add_row(req_row(mk_req(1, 0, 0, 0, 0, 1), 1,
                        mk_summary(0, 0), '0));
        add_row(req_row(mk_req(0, 1, 399, 0, 0, 1), 2,
                        mk_pair(0, 1, 0, 0, 0), mk_summary(1, 1)));
        add_row(req_row(mk_req(0, 1, 400, 0, 0, 1), 1,
                        mk_summary(0, 1), '0));
        add_row(req_row(mk_req(0, 7, COORD_MAX, COORD_MAX, COORD_MAX, 0),
                        0, '0, '0));
        add_row(req_row(mk_req(0, 6, COORD_MIN, COORD_MIN, COORD_MIN, 1),
                        1, mk_summary(0, 1), '0));
        add_row(req_row(mk_req(1, 2, COORD_MIN, COORD_MIN, COORD_MIN, 0),
                        0, '0, '0));
        add_row(req_row(mk_req(0, 3, COORD_MIN + 1, COORD_MIN, COORD_MIN, 1),
                        0, '0, '0));
        add_row(req_row(mk_req(1, 5, 100, -100, 7, 1), 1,
                        mk_summary(0, 0), '0));
        add_row(cfg_row(16'd0));
        add_row(req_row(mk_req(0, 4, 100, -100, 7, 1), 1,
                        mk_summary(0, 0), '0));
        add_row(cfg_row(16'hFFFF));
        add_row(req_row(mk_req(0, 0, 60000, 0, 0, 1), 0, '0, '0));
        add_row(req_row(mk_req(0, 1, COORD_MIN, COORD_MAX, 0, 0), 0, '0, '0));
        add_row(req_row(mk_req(0, 7, COORD_MAX, COORD_MIN, 1, 1), 0, '0, '0));
        add_row(cfg_row(16'd1));
        add_row(req_row(mk_req(0, 2, 100, -100, 7, 1), 0, '0, '0));
        add_row(cfg_row(16'd400));
        add_row(req_row(mk_req(1, 0, 3, 4, 0, 0), 0, '0, '0));
        add_row(req_row(mk_req(0, 1, 0, 0, 0, 1), 0, '0, '0));

        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part.
        foreach (directed[k])
        begin
            if (directed[k].kind == ROW_CFG)
            begin
                wait_idle();
                write_near_limit(directed[k].limit);
            end
            else
            begin
                send_request(directed[k].r, directed[k].n_typed == 0);
                if (directed[k].n_typed > 0)
                    owe_result(directed[k].exp_a);
                if (directed[k].n_typed > 1)
                    owe_result(directed[k].exp_b);
            end
        end

        // Random part in three phases, idling at 38, 64 and 0 percent, with a new limit between them.
        run_random_steps(35, 38);
        wait_idle();
        write_near_limit(pick_limit());
        run_random_steps(35, 64);
        wait_idle();
        write_near_limit(pick_limit());
        run_random_steps(35, 0);
        wait_idle();

        $display("Sent %0d position requests over %0d near limit settings.",
                 requests_sent, limit_settings);
        $display("Checked %0d close pair reports and %0d timestep summaries.",
                 pair_reports, summaries);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* sim.f */
src/ppcc_pkg.sv
src/ppcc_point_mem.sv
src/ppcc_sq_unit.sv
src/ppcc_ctrl.sv
src/pairwise_proximity_collision_check_core.sv
test/tb_pairwise_proximity_collision_check_core.sv
